// ===== hdl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg: shared definitions for the MIPS subset execute stage
// Opcode and function codes, status and access-size codes, reset addresses
// and the register-file write request type.
// ----------------------------------------------------------------------------
package mse_pkg;

   localparam int REG_W  = 32;
   localparam int REG_AW = 5;
   localparam int REG_N  = 32;

   localparam logic [31:0] RESET_PC     = 32'hBFC0_0000;
   localparam logic [31:0] RESET_FOLLOW = 32'hBFC0_0004;
   localparam logic [31:0] SEG_MASK     = 32'hF000_0000;
   localparam logic [1:0]  ALIGN_MASK   = 2'b11;

   // Primary opcodes, instruction bits 31..26.
   localparam logic [5:0] OP_SPECIAL = 6'b000000;
   localparam logic [5:0] OP_J       = 6'b000010;
   localparam logic [5:0] OP_JAL     = 6'b000011;
   localparam logic [5:0] OP_BEQ     = 6'b000100;
   localparam logic [5:0] OP_BNE     = 6'b000101;
   localparam logic [5:0] OP_ADDI    = 6'b001000;
   localparam logic [5:0] OP_ADDIU   = 6'b001001;
   localparam logic [5:0] OP_ANDI    = 6'b001100;
   localparam logic [5:0] OP_ORI     = 6'b001101;
   localparam logic [5:0] OP_LUI     = 6'b001111;
   localparam logic [5:0] OP_LB      = 6'b100000;
   localparam logic [5:0] OP_LW      = 6'b100011;
   localparam logic [5:0] OP_SB      = 6'b101000;
   localparam logic [5:0] OP_SH      = 6'b101001;
   localparam logic [5:0] OP_SW      = 6'b101011;

   // Function codes of the SPECIAL opcode, instruction bits 5..0.
   localparam logic [5:0] FN_SLL  = 6'b000000;
   localparam logic [5:0] FN_JR   = 6'b001000;
   localparam logic [5:0] FN_ADD  = 6'b100000;
   localparam logic [5:0] FN_ADDU = 6'b100001;
   localparam logic [5:0] FN_AND  = 6'b100100;
   localparam logic [5:0] FN_OR   = 6'b100101;
   localparam logic [5:0] FN_SLTU = 6'b101011;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNIMPL    = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_UNALIGNED = 2'd3;

   // Data access sizes.
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;

   // Two register writes can retire with one word: the result of the
   // instruction (port a) and the value of an older load (port b).
   typedef struct packed {
      logic              a_en;
      logic [REG_AW-1:0] a_addr;
      logic [REG_W-1:0]  a_data;
      logic              b_en;
      logic [REG_AW-1:0] b_addr;
      logic [REG_W-1:0]  b_data;
   } rf_write_type;

endpackage

// ===== hdl/mips_subset_execute_stage.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_stage: execute stage for a MIPS integer subset
// Executes one instruction word per input word, keeps the register file,
// the PC pair with branch delay slot and a one-entry load delay slot.
// ----------------------------------------------------------------------------
// Usage:
//    The request channel carries an instruction word fetched at the address
//    that the previous result gave on rsp_next_fetch_addr, together with the
//    read data for the previous word's load. The response channel returns the
//    executed address, a status code, the data access request and the next
//    fetch address. Both channels use valid/stall.
//    A word accepted into the execute holding register moves on into the output
//    register, from which its result shows on the response port. The block takes
//    one word per cycle while the output is taken; the register-file read in the
//    accept cycle and the bypass from the previous write allow that rate.
//    Reset (synchronous) returns the PC to the boot vector, empties the load
//    slot and clears the register file at once through per-entry valid bits.
//    When the receiver stalls, the output register holds its word, the word
//    in execute waits and req_stall rises until the output is taken.
//    csr_write_enable updates the isolated-cache bit; write it only while no
//    word is in flight.
// ----------------------------------------------------------------------------
module mips_subset_execute_stage
   import mse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_load_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_instr_addr,
   output logic [1:0]  rsp_status,
   output logic        rsp_mem_read,
   output logic        rsp_mem_write,
   output logic [1:0]  rsp_mem_size,
   output logic [31:0] rsp_mem_addr,
   output logic [31:0] rsp_mem_wdata,
   output logic [31:0] rsp_next_fetch_addr
);

   // Architectural state.
   logic        cache_iso_ff;
   logic [31:0] cur_pc_ff, cur_pc_in;
   logic [31:0] following_pc_ff, following_pc_in;
   logic [4:0]  pending_reg_ff, pending_reg_in;
   logic [31:0] pending_value_ff, pending_value_in;
   logic        awaiting_ff, awaiting_in;
   logic        pending_byte_ff, pending_byte_in;

   // Execute stage holding register.
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_instr_ff;
   logic [31:0] s1_ld_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_instr_addr_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_mem_read_ff;
   logic        rsp_mem_write_ff;
   logic [1:0]  rsp_mem_size_ff;
   logic [31:0] rsp_mem_addr_ff;
   logic [31:0] rsp_mem_wdata_ff;
   logic [31:0] rsp_next_fetch_ff;

   logic        accept;
   logic        s1_go;
   logic        commit;

   logic [4:0]  rf_addr_s;
   logic [4:0]  rf_addr_t;
   logic [31:0] vs;
   logic [31:0] vt;
   rf_write_type rf_wr;

   // Decoded fields of the word in execute.
   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [15:0] imm;
   logic [31:0] simm;

   // Execute results.
   logic [31:0] pv;
   logic [31:0] add_b;
   logic [31:0] sum;
   logic        ovf;
   logic [31:0] seq_pc;
   logic [31:0] jump_target;
   logic [31:0] branch_target;
   logic [1:0]  status;
   logic [4:0]  wreg;
   logic [31:0] wval;
   logic [31:0] nxt;
   logic        mrd;
   logic        mwr;
   logic [1:0]  msz;
   logic [31:0] maddr;
   logic [31:0] mwd;
   logic        is_load;
   logic        is_store;
   logic        ld_byte;
   logic        do_write;
   logic        new_load;

   // ------------------------------------------------------------------------
   // Handshake. The execute word moves on whenever the output register is
   // empty or being taken, so a new word can enter every cycle.
   // ------------------------------------------------------------------------
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;
   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   // The register file is read with the incoming word's source fields. When
   // the execute word is held, it reads its own fields again so that its
   // operands stay current.
   assign rf_addr_s = accept ? req_instr_word[25:21] : rs;
   assign rf_addr_t = accept ? req_instr_word[20:16] : rt;

   mse_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_0 (rf_addr_s),
      .rd_addr_1 (rf_addr_t),
      .wr        (rf_wr),
      .rd_data_0 (vs),
      .rd_data_1 (vt)
   );

   // ------------------------------------------------------------------------
   // Decode and execute.
   // ------------------------------------------------------------------------
   assign op   = s1_instr_ff[31:26];
   assign fn   = s1_instr_ff[5:0];
   assign rs   = s1_instr_ff[25:21];
   assign rt   = s1_instr_ff[20:16];
   assign rd   = s1_instr_ff[15:11];
   assign sh   = s1_instr_ff[10:6];
   assign imm  = s1_instr_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};

   // Load data of the previous word lands in the load slot value now.
   assign pv = awaiting_ff ? (pending_byte_ff ? {{24{s1_ld_ff[7]}}, s1_ld_ff[7:0]} : s1_ld_ff)
                           : pending_value_ff;

   // One adder serves register adds, immediate adds and data addresses.
   assign add_b = (op == OP_SPECIAL) ? vt : simm;
   assign sum   = vs + add_b;
   assign ovf   = ((vs[31] ^ sum[31]) & (add_b[31] ^ sum[31]));

   assign seq_pc        = following_pc_ff + 32'd4;
   assign jump_target   = (following_pc_ff & SEG_MASK) | {4'b0, s1_instr_ff[25:0], 2'b00};
   assign branch_target = following_pc_ff + {simm[29:0], 2'b00};

   always_comb begin
      status   = ST_OK;
      wreg     = '0;
      wval     = '0;
      nxt      = seq_pc;
      mrd      = 1'b0;
      mwr      = 1'b0;
      msz      = SZ_BYTE;
      maddr    = '0;
      mwd      = '0;
      is_load  = 1'b0;
      is_store = 1'b0;
      ld_byte  = 1'b0;
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_SLL: begin
                  wreg = rd;
                  wval = vt << sh;
               end
               FN_JR: begin
                  nxt = vs;
               end
               FN_ADD: begin
                  wreg = rd;
                  wval = sum;
                  if (ovf) begin
                     status = ST_OVERFLOW;
                  end
               end
               FN_ADDU: begin
                  wreg = rd;
                  wval = sum;
               end
               FN_AND: begin
                  wreg = rd;
                  wval = vs & vt;
               end
               FN_OR: begin
                  wreg = rd;
                  wval = vs | vt;
               end
               FN_SLTU: begin
                  wreg = rd;
                  wval = {31'b0, (vs < vt)};
               end
               default: begin
                  status = ST_UNIMPL;
               end
            endcase
         end
         OP_J: begin
            nxt = jump_target;
         end
         OP_JAL: begin
            wreg = 5'd31;
            wval = seq_pc;
            nxt  = jump_target;
         end
         OP_BEQ: begin
            if (vs == vt) begin
               nxt = branch_target;
            end
         end
         OP_BNE: begin
            if (vs != vt) begin
               nxt = branch_target;
            end
         end
         OP_ADDI: begin
            wreg = rt;
            wval = sum;
            if (ovf) begin
               status = ST_OVERFLOW;
            end
         end
         OP_ADDIU: begin
            wreg = rt;
            wval = sum;
         end
         OP_LUI: begin
            wreg = rt;
            wval = {imm, 16'b0};
         end
         OP_ANDI: begin
            wreg = rt;
            wval = vs & {16'b0, imm};
         end
         OP_ORI: begin
            wreg = rt;
            wval = vs | {16'b0, imm};
         end
         OP_LB, OP_LW: begin
            is_load = 1'b1;
            ld_byte = (op == OP_LB);
            if (!cache_iso_ff) begin
               mrd   = 1'b1;
               msz   = (op == OP_LB) ? SZ_BYTE : SZ_WORD;
               maddr = sum;
            end
         end
         OP_SB, OP_SH, OP_SW: begin
            is_store = 1'b1;
            if (!cache_iso_ff) begin
               mwr   = 1'b1;
               msz   = (op == OP_SB) ? SZ_BYTE : ((op == OP_SH) ? SZ_HALF : SZ_WORD);
               maddr = sum;
               mwd   = vt;
            end
         end
         default: begin
            status = ST_UNIMPL;
         end
      endcase
      // A misaligned PC overrides everything decoded from the word.
      if ((cur_pc_ff[1:0] & ALIGN_MASK) != 2'b00) begin
         status = ST_UNALIGNED;
      end
   end

   // Loads never write a register now; an isolated store neither writes a register nor issues an access.
   assign do_write = !is_load && !(is_store && cache_iso_ff);
   assign new_load = is_load && !cache_iso_ff;
   // Error words leave every piece of state untouched.
   assign commit   = s1_go && (status == ST_OK);

   // Port a retires the instruction's own result. Port b retires an older
   // load into its register unless this instruction overwrites it directly.
   always_comb begin
      rf_wr.a_en   = commit && do_write && (wreg != '0);
      rf_wr.a_addr = wreg;
      rf_wr.a_data = wval;
      rf_wr.b_en   = commit && do_write && (pending_reg_ff != '0) && (pending_reg_ff != wreg);
      rf_wr.b_addr = pending_reg_ff;
      rf_wr.b_data = pv;
   end

   always_comb begin
      cur_pc_in        = following_pc_ff;
      following_pc_in  = nxt;
      pending_value_in = pv;
      awaiting_in      = new_load;
      pending_reg_in   = pending_reg_ff;
      pending_byte_in  = pending_byte_ff;
      if (new_load) begin
         pending_reg_in  = rt;
         pending_byte_in = ld_byte;
      end else if (do_write) begin
         pending_reg_in = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_iso_ff     <= 1'b0;
         cur_pc_ff        <= RESET_PC;
         following_pc_ff  <= RESET_FOLLOW;
         pending_reg_ff   <= '0;
         pending_value_ff <= '0;
         awaiting_ff      <= 1'b0;
         pending_byte_ff  <= 1'b0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cache_iso_ff <= csr_write_data;
         end
         if (commit) begin
            cur_pc_ff        <= cur_pc_in;
            following_pc_ff  <= following_pc_in;
            pending_reg_ff   <= pending_reg_in;
            pending_value_ff <= pending_value_in;
            awaiting_ff      <= awaiting_in;
            pending_byte_ff  <= pending_byte_in;
         end
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instr_word;
         s1_ld_ff    <= req_load_data;
      end
      if (s1_go) begin
         rsp_instr_addr_ff <= cur_pc_ff;
         rsp_status_ff     <= status;
         if (status == ST_OK) begin
            rsp_mem_read_ff   <= mrd;
            rsp_mem_write_ff  <= mwr;
            rsp_mem_size_ff   <= msz;
            rsp_mem_addr_ff   <= maddr;
            rsp_mem_wdata_ff  <= mwd;
            rsp_next_fetch_ff <= following_pc_ff;
         end else begin
            rsp_mem_read_ff   <= 1'b0;
            rsp_mem_write_ff  <= 1'b0;
            rsp_mem_size_ff   <= SZ_BYTE;
            rsp_mem_addr_ff   <= '0;
            rsp_mem_wdata_ff  <= '0;
            rsp_next_fetch_ff <= cur_pc_ff;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_instr_addr      = rsp_instr_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_mem_read        = rsp_mem_read_ff;
   assign rsp_mem_write       = rsp_mem_write_ff;
   assign rsp_mem_size        = rsp_mem_size_ff;
   assign rsp_mem_addr        = rsp_mem_addr_ff;
   assign rsp_mem_wdata       = rsp_mem_wdata_ff;
   assign rsp_next_fetch_addr = rsp_next_fetch_ff;

`ifndef NO_ASSERTIONS
   a_error_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (!rsp_mem_read && !rsp_mem_write && rsp_next_fetch_addr == rsp_instr_addr))
      else $error("error word issued an access or moved the PC");

   a_isolated_no_access: assert property (@(posedge clock) disable iff (reset)
      (s1_go && cache_iso_ff) |=> !(rsp_mem_read || rsp_mem_write))
      else $error("access issued while the cache is isolated");

   a_held_word_stable: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_instr_ff) && $stable(s1_ld_ff)))
      else $error("execute word changed while held");

   a_error_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      (s1_go && status != ST_OK) |=> $stable(cur_pc_ff) && $stable(pending_reg_ff))
      else $error("error word changed state");
`endif

endmodule

// ===== hdl/mse_regfile.sv =====
// ----------------------------------------------------------------------------
// mse_regfile: two-write, two-read register file
// Two synchronous banks, one per write port, with a per-entry bank selector
// and valid bits. Reads resolve in the cycle after the address is presented and
// see writes made at the same clock edge through a bypass.
// ----------------------------------------------------------------------------
module mse_regfile
   import mse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [REG_AW-1:0] rd_addr_0,
   input  logic [REG_AW-1:0] rd_addr_1,
   input  rf_write_type      wr,
   output logic [REG_W-1:0]  rd_data_0,
   output logic [REG_W-1:0]  rd_data_1
);

   logic [REG_W-1:0]  bank_a_mem [REG_N];
   logic [REG_W-1:0]  bank_b_mem [REG_N];

   logic [REG_W-1:0]  rda_ff [2];
   logic [REG_W-1:0]  rdb_ff [2];
   logic [REG_AW-1:0] raddr_ff [2];
   logic [REG_AW-1:0] raddr_in [2];
   logic [REG_W-1:0]  rd_data [2];

   logic [REG_N-1:0]  vld_ff;
   logic [REG_N-1:0]  sel_b_ff;
   logic              fwd_a_ff;
   logic              fwd_b_ff;
   logic [REG_AW-1:0] fwd_a_addr_ff;
   logic [REG_AW-1:0] fwd_b_addr_ff;
   logic [REG_W-1:0]  fwd_a_data_ff;
   logic [REG_W-1:0]  fwd_b_data_ff;

   assign raddr_in[0] = rd_addr_0;
   assign raddr_in[1] = rd_addr_1;

   // Bank memories: read-first, the bypass covers a same-edge write.
   always_ff @(posedge clock) begin
      if (wr.a_en) begin
         bank_a_mem[wr.a_addr] <= wr.a_data;
      end
      if (wr.b_en) begin
         bank_b_mem[wr.b_addr] <= wr.b_data;
      end
      for (int p = 0; p < 2; p++) begin
         rda_ff[p]   <= bank_a_mem[raddr_in[p]];
         rdb_ff[p]   <= bank_b_mem[raddr_in[p]];
         raddr_ff[p] <= raddr_in[p];
      end
      fwd_a_addr_ff <= wr.a_addr;
      fwd_a_data_ff <= wr.a_data;
      fwd_b_addr_ff <= wr.b_addr;
      fwd_b_data_ff <= wr.b_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         sel_b_ff <= '0;
         fwd_a_ff <= 1'b0;
         fwd_b_ff <= 1'b0;
      end else begin
         fwd_a_ff <= wr.a_en;
         fwd_b_ff <= wr.b_en;
         if (wr.a_en) begin
            vld_ff[wr.a_addr]   <= 1'b1;
            sel_b_ff[wr.a_addr] <= 1'b0;
         end
         if (wr.b_en) begin
            vld_ff[wr.b_addr]   <= 1'b1;
            sel_b_ff[wr.b_addr] <= 1'b1;
         end
      end
   end

   // Register zero and never-written entries read as zero.
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         if (raddr_ff[p] == '0) begin
            rd_data[p] = '0;
         end else if (fwd_a_ff && fwd_a_addr_ff == raddr_ff[p]) begin
            rd_data[p] = fwd_a_data_ff;
         end else if (fwd_b_ff && fwd_b_addr_ff == raddr_ff[p]) begin
            rd_data[p] = fwd_b_data_ff;
         end else if (!vld_ff[raddr_ff[p]]) begin
            rd_data[p] = '0;
         end else if (sel_b_ff[raddr_ff[p]]) begin
            rd_data[p] = rdb_ff[p];
         end else begin
            rd_data[p] = rda_ff[p];
         end
      end
   end

   assign rd_data_0 = rd_data[0];
   assign rd_data_1 = rd_data[1];

`ifndef NO_ASSERTIONS
   a_ports_disjoint: assert property (@(posedge clock) disable iff (reset)
      !(wr.a_en && wr.b_en && wr.a_addr == wr.b_addr))
      else $error("both write ports hit the same register");

   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      !((wr.a_en && wr.a_addr == '0) || (wr.b_en && wr.b_addr == '0)))
      else $error("write to register zero");

   a_sel_a: assert property (@(posedge clock) disable iff (reset)
      wr.a_en |=> (vld_ff[$past(wr.a_addr)] && !sel_b_ff[$past(wr.a_addr)]))
      else $error("port a write not tracked by bank selector");

   a_sel_b: assert property (@(posedge clock) disable iff (reset)
      wr.b_en |=> (vld_ff[$past(wr.b_addr)] && sel_b_ff[$past(wr.b_addr)]))
      else $error("port b write not tracked by bank selector");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for mips_subset_execute_stage
// Feeds instruction words with load data and predicts every result word.
// A directed part covers each opcode, the arithmetic extremes, overflow and
// unimplemented-opcode faults, the load delay slot and the isolated cache.
// Random instruction streams then run under changing sender and receiver
// idling and a long receiver hold. The run closes with an unaligned PC.
// ----------------------------------------------------------------------------
module tb_top;
   import mse_pkg::*;

   // Opcode and function codes that the block does not implement.
   localparam logic [5:0] OP_REGIMM  = 6'b000001;
   localparam logic [5:0] OP_COP0    = 6'b010000;
   localparam logic [5:0] FN_SYSCALL = 6'b001100;
   localparam logic [5:0] FN_UNUSED  = 6'b111111;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HOLD_CYCLES  = 120;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES  = 8;
   localparam int unsigned MAX_REPORTS  = 10;

   // One result word as the response channel shows it.
   typedef struct packed {
      logic [31:0] instr_addr;
      logic [1:0]  status;
      logic        mem_read;
      logic        mem_write;
      logic [1:0]  mem_size;
      logic [31:0] mem_addr;
      logic [31:0] mem_wdata;
      logic [31:0] next_fetch_addr;
   } retire_word_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_instr_word;
   logic [31:0] req_load_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_instr_addr;
   logic [1:0]  rsp_status;
   logic        rsp_mem_read;
   logic        rsp_mem_write;
   logic [1:0]  rsp_mem_size;
   logic [31:0] rsp_mem_addr;
   logic [31:0] rsp_mem_wdata;
   logic [31:0] rsp_next_fetch_addr;

   // Architectural state as the bench expects it to be after the last
   // accepted word: registers, PC pair and the load delay slot.
   logic [31:0] rf [REG_N];
   logic [31:0] pc_now;
   logic [31:0] pc_follow;
   logic [4:0]  ld_reg;
   logic [31:0] ld_value;
   logic        ld_wait;
   logic        ld_byte_flag;
   logic        iso_bit;

   retire_word_type retire_words_due [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_request;
   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned words_checked;
   int unsigned fault_words;
   int unsigned loads_seen;
   int unsigned stores_seen;

   mips_subset_execute_stage i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_instr_word      (req_instr_word),
      .req_load_data       (req_load_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_instr_addr      (rsp_instr_addr),
      .rsp_status          (rsp_status),
      .rsp_mem_read        (rsp_mem_read),
      .rsp_mem_write       (rsp_mem_write),
      .rsp_mem_size        (rsp_mem_size),
      .rsp_mem_addr        (rsp_mem_addr),
      .rsp_mem_wdata       (rsp_mem_wdata),
      .rsp_next_fetch_addr (rsp_next_fetch_addr)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit. It sits far above the slowest legal run, so reaching it
   // means the block stopped answering.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Instruction encoders.
   // ------------------------------------------------------------------------
   function automatic logic [31:0] r_type(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
      return {OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] j_type(logic [5:0] op, logic [25:0] target);
      return {op, target};
   endfunction

   // ------------------------------------------------------------------------
   // Predictor. Executes one word against the expected state, commits the
   // state change and returns the result word the block must produce.
   // A faulting word returns its status and leaves every bit of state alone,
   // so a load that was waiting for data still waits for it.
   // ------------------------------------------------------------------------
   function automatic retire_word_type execute_word(logic [31:0] iw, logic [31:0] ld);
      retire_word_type r;
      logic [5:0]   op;
      logic [5:0]   fn;
      logic [4:0]   rs;
      logic [4:0]   rt;
      logic [4:0]   rd;
      logic [4:0]   wreg;
      logic [31:0]  vs;
      logic [31:0]  vt;
      logic [31:0]  simm;
      logic [31:0]  delay_pc;
      logic [31:0]  nxt;
      logic [31:0]  pv;
      logic [31:0]  sum;
      logic [31:0]  wval;
      logic [1:0]   st;
      logic         do_write;
      logic         new_load;
      logic         is_byte;
      logic         touch;

      r = '0;
      r.instr_addr      = pc_now;
      r.next_fetch_addr = pc_now;
      if ((pc_now[1:0] & ALIGN_MASK) != 2'b00) begin
         r.status = ST_UNALIGNED;
         return r;
      end

      op       = iw[31:26];
      fn       = iw[5:0];
      rs       = iw[25:21];
      rt       = iw[20:16];
      rd       = iw[15:11];
      vs       = rf[rs];
      vt       = rf[rt];
      simm     = {{16{iw[15]}}, iw[15:0]};
      delay_pc = pc_follow;
      nxt      = pc_follow + 32'd4;
      st       = ST_OK;
      wreg     = '0;
      wval     = '0;
      do_write = 1'b1;
      new_load = 1'b0;
      is_byte  = 1'b0;
      touch    = 1'b1;

      // Data for an outstanding load rides on this word.
      pv = ld_value;
      if (ld_wait)
         pv = ld_byte_flag ? {{24{ld[7]}}, ld[7:0]} : ld;

      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_SLL: begin
                  wreg = rd;
                  wval = vt << iw[10:6];
               end
               FN_JR: nxt = vs;
               FN_ADD: begin
                  sum = vs + vt;
                  if (((vs ^ sum) & (vt ^ sum)) >> 31)
                     st = ST_OVERFLOW;
                  wreg = rd;
                  wval = sum;
               end
               FN_ADDU: begin
                  wreg = rd;
                  wval = vs + vt;
               end
               FN_AND: begin
                  wreg = rd;
                  wval = vs & vt;
               end
               FN_OR: begin
                  wreg = rd;
                  wval = vs | vt;
               end
               FN_SLTU: begin
                  wreg = rd;
                  wval = (vs < vt) ? 32'd1 : 32'd0;
               end
               default: st = ST_UNIMPL;
            endcase
         end
         OP_J: nxt = (delay_pc & SEG_MASK) | {4'b0, iw[25:0], 2'b00};
         OP_JAL: begin
            wreg = 5'd31;
            wval = nxt;
            nxt  = (delay_pc & SEG_MASK) | {4'b0, iw[25:0], 2'b00};
         end
         OP_BEQ: if (vs == vt) nxt = delay_pc + (simm << 2);
         OP_BNE: if (vs != vt) nxt = delay_pc + (simm << 2);
         OP_ADDI: begin
            sum = vs + simm;
            if (((vs ^ sum) & (simm ^ sum)) >> 31)
               st = ST_OVERFLOW;
            wreg = rt;
            wval = sum;
         end
         OP_ADDIU: begin
            wreg = rt;
            wval = vs + simm;
         end
         OP_LUI: begin
            wreg = rt;
            wval = {iw[15:0], 16'h0000};
         end
         OP_ANDI: begin
            wreg = rt;
            wval = vs & {16'h0000, iw[15:0]};
         end
         OP_ORI: begin
            wreg = rt;
            wval = vs | {16'h0000, iw[15:0]};
         end
         OP_LB, OP_LW: begin
            do_write = 1'b0;
            if (iso_bit) begin
               touch = 1'b0;
            end else begin
               new_load   = 1'b1;
               is_byte    = (op == OP_LB);
               r.mem_read = 1'b1;
               r.mem_size = is_byte ? SZ_BYTE : SZ_WORD;
               r.mem_addr = vs + simm;
            end
         end
         OP_SB, OP_SH, OP_SW: begin
            if (iso_bit) begin
               do_write = 1'b0;
               touch    = 1'b0;
            end else begin
               r.mem_write = 1'b1;
               r.mem_size  = (op == OP_SB) ? SZ_BYTE : (op == OP_SH) ? SZ_HALF : SZ_WORD;
               r.mem_addr  = vs + simm;
               r.mem_wdata = vt;
            end
         end
         default: st = ST_UNIMPL;
      endcase

      if (st != ST_OK) begin
         r          = '0;
         r.instr_addr      = pc_now;
         r.status          = st;
         r.next_fetch_addr = pc_now;
         return r;
      end

      // Commit. A new load replaces whatever load was pending; any other
      // word that writes retires the pending load, unless it writes the
      // same register itself, in which case the load is dropped.
      if (touch || ld_wait)
         ld_value = pv;
      ld_wait = 1'b0;
      if (new_load) begin
         ld_reg       = rt;
         ld_byte_flag = is_byte;
         ld_wait      = 1'b1;
      end else if (do_write) begin
         if (wreg == ld_reg)
            ld_reg = '0;
         rf[wreg] = wval;
         if (ld_reg != '0)
            rf[ld_reg] = ld_value;
         ld_reg = '0;
         rf[0]  = '0;
      end
      pc_now    = delay_pc;
      pc_follow = nxt;
      r.next_fetch_addr = delay_pc;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Random stimulus.
   // ------------------------------------------------------------------------

   // Mostly a handful of low registers, so words depend on each other often.
   function automatic logic [4:0] pick_reg();
      logic [4:0] r;
      if ($urandom_range(3) == 0)
         r = 5'($urandom_range(31));
      else
         r = 5'($urandom_range(7));
      return r;
   endfunction

   function automatic logic [31:0] random_load_data();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0: v = '0;
         1: v = '1;
         2: v[7:0] = 8'h80;
         3: v[7:0] = 8'h7F;
         default: ;
      endcase
      return v;
   endfunction

   // Well-formed instructions with random fields, a few unimplemented ones
   // and some raw noise. A jump through a register never goes to an
   // unaligned address here: that state only clears with reset, so it is
   // reached once, at the very end of the run.
   function automatic logic [31:0] random_instr();
      logic [31:0] iw;
      logic [31:0] rnd;
      logic [5:0]  code;
      int unsigned pick;

      rnd  = $urandom;
      pick = $urandom_range(99);
      if (pick < 30) begin
         case ($urandom_range(5))
            0: code = FN_SLL;
            1: code = FN_ADD;
            2: code = FN_ADDU;
            3: code = FN_AND;
            4: code = FN_OR;
            default: code = FN_SLTU;
         endcase
         iw = r_type(code, pick_reg(), pick_reg(), pick_reg(), rnd[10:6]);
      end else if (pick < 50) begin
         case ($urandom_range(4))
            0: code = OP_ADDI;
            1: code = OP_ADDIU;
            2: code = OP_LUI;
            3: code = OP_ANDI;
            default: code = OP_ORI;
         endcase
         iw = i_type(code, pick_reg(), pick_reg(), rnd[15:0]);
      end else if (pick < 62) begin
         code = ($urandom_range(1) == 0) ? OP_LB : OP_LW;
         iw = i_type(code, pick_reg(), pick_reg(), rnd[15:0]);
      end else if (pick < 72) begin
         case ($urandom_range(2))
            0: code = OP_SB;
            1: code = OP_SH;
            default: code = OP_SW;
         endcase
         iw = i_type(code, pick_reg(), pick_reg(), rnd[15:0]);
      end else if (pick < 82) begin
         code = ($urandom_range(1) == 0) ? OP_BEQ : OP_BNE;
         iw = i_type(code, pick_reg(), pick_reg(), rnd[15:0]);
      end else if (pick < 88) begin
         code = ($urandom_range(1) == 0) ? OP_J : OP_JAL;
         iw = j_type(code, rnd[25:0]);
      end else if (pick < 92) begin
         iw = r_type(FN_JR, pick_reg(), '0, '0, '0);
      end else if (pick < 96) begin
         case ($urandom_range(3))
            0: iw = j_type(OP_COP0, rnd[25:0]);
            1: iw = j_type(OP_REGIMM, rnd[25:0]);
            2: iw = r_type(FN_SYSCALL, rnd[25:21], rnd[20:16], rnd[15:11], rnd[10:6]);
            default: iw = r_type(FN_UNUSED, rnd[25:21], rnd[20:16], rnd[15:11], rnd[10:6]);
         endcase
      end else begin
         iw = rnd;
      end

      if (iw[31:26] == OP_SPECIAL && iw[5:0] == FN_JR && rf[iw[25:21]][1:0] != 2'b00)
         iw[25:21] = '0;
      return iw;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Called just after a falling edge; returns just after the
   // falling edge that follows acceptance, with valid still high so the next
   // word can follow back to back.
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [31:0] iw, input logic [31:0] ld);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_instr_word = iw;
      req_load_data  = ld;
      do
         @(posedge clock);
      while (req_stall);
      retire_words_due.push_back(execute_word(iw, ld));
      @(negedge clock);
   endtask

   // The sender stops until every expected word has come back, then lets the pipeline settle.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (retire_words_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // The isolation bit is only written with nothing in flight.
   task automatic set_isolation(input logic value);
      wait_drained();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      iso_bit          = value;
   endtask

   // ------------------------------------------------------------------------
   // Response side. The receiver stalls at random, or for a long stretch
   // when a test asks for it.
   // ------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall    = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Every word taken from the response port is checked against the oldest
   // expected word. All fields are compared at once, X included.
   always @(posedge clock) begin
      retire_word_type seen;
      retire_word_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_instr_addr, rsp_status, rsp_mem_read, rsp_mem_write, rsp_mem_size,
                 rsp_mem_addr, rsp_mem_wdata, rsp_next_fetch_addr};
         if (retire_words_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("cycle %0d: unexpected result word at addr %h", cycle_count,
                        rsp_instr_addr);
         end else begin
            due = retire_words_due.pop_front();
            words_checked++;
            if (due.status != ST_OK)
               fault_words++;
            if (due.mem_read)
               loads_seen++;
            if (due.mem_write)
               stores_seen++;
            if (seen !== due) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("cycle %0d: mismatch", cycle_count);
                  $display("  expected addr=%h st=%0d rd=%b wr=%b sz=%0d maddr=%h wdata=%h next=%h",
                           due.instr_addr, due.status, due.mem_read, due.mem_write,
                           due.mem_size, due.mem_addr, due.mem_wdata, due.next_fetch_addr);
                  $display("  actual   addr=%h st=%0d rd=%b wr=%b sz=%0d maddr=%h wdata=%h next=%h",
                           seen.instr_addr, seen.status, seen.mem_read, seen.mem_write,
                           seen.mem_size, seen.mem_addr, seen.mem_wdata, seen.next_fetch_addr);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Every non-memory opcode, the arithmetic extremes and both fault kinds that
   // leave the PC aligned.
   task automatic test_opcodes();
      send_word(32'h0000_0000, 32'hFFFF_FFFF);                  // all-zero word is a nop
      send_word(i_type(OP_LUI, 0, 1, 16'h7FFF), 32'h0000_0000);
      send_word(i_type(OP_ORI, 1, 1, 16'hFFFF), random_load_data());  // r1 = max positive
      send_word(i_type(OP_ADDIU, 0, 2, 16'hFFFF), random_load_data()); // r2 = -1
      send_word(r_type(FN_ADD, 1, 1, 3, 0), random_load_data());      // overflow
      send_word(i_type(OP_ADDI, 1, 3, 16'h0001), random_load_data()); // overflow
      send_word(i_type(OP_ADDI, 2, 4, 16'h0001), random_load_data()); // -1 + 1, no overflow
      send_word(r_type(FN_ADDU, 1, 2, 5, 0), random_load_data());
      send_word(r_type(FN_AND, 1, 2, 6, 0), random_load_data());
      send_word(r_type(FN_OR, 0, 2, 7, 0), random_load_data());
      send_word(r_type(FN_SLTU, 1, 2, 8, 0), random_load_data());
      send_word(r_type(FN_SLL, 0, 2, 9, 31), random_load_data());
      send_word(i_type(OP_ANDI, 2, 10, 16'hFFFF), random_load_data());
      send_word(32'hFFFF_FFFF, 32'h0000_0000);                  // all-ones word is unimplemented
      send_word(j_type(OP_COP0, '0), random_load_data());
      send_word(r_type(FN_UNUSED, 1, 2, 3, 4), random_load_data());
      // Control flow, each with its delay slot.
      send_word(i_type(OP_BEQ, 0, 0, 16'hFFFF), random_load_data());
      send_word(32'h0000_0000, random_load_data());
      send_word(i_type(OP_BNE, 1, 2, 16'h7FFF), random_load_data());
      send_word(r_type(FN_ADDU, 1, 0, 11, 0), random_load_data());
      send_word(j_type(OP_J, 26'h3FF_FFFF), random_load_data());
      send_word(32'h0000_0000, random_load_data());
      send_word(j_type(OP_JAL, '0), random_load_data());
      send_word(32'h0000_0000, random_load_data());
      send_word(r_type(FN_JR, 31, 0, 0, 0), random_load_data());
      send_word(32'h0000_0000, random_load_data());
   endtask

   // The load delay slot: sign extension of a byte, two loads in a row,
   // a direct write to the load target, a fault while data is awaited and
   // a load into r0.
   task automatic test_load_slot();
      send_word(i_type(OP_LB, 1, 11, 16'hFFFF), random_load_data());
      send_word(i_type(OP_SB, 2, 11, 16'h0000), 32'h1234_5680);  // r11 becomes ffffff80
      send_word(i_type(OP_SH, 1, 11, 16'h8000), random_load_data());
      send_word(i_type(OP_LW, 0, 12, 16'h7FFF), random_load_data());
      send_word(i_type(OP_LW, 2, 13, 16'h0004), 32'hFFFF_FFFF);  // r12 load is lost
      send_word(i_type(OP_ORI, 0, 13, 16'h5A5A), 32'h0000_0000); // cancels the r13 load
      send_word(i_type(OP_SW, 0, 13, 16'h0008), random_load_data());
      send_word(i_type(OP_LW, 0, 14, 16'h0000), random_load_data());
      send_word(j_type(OP_COP0, '0), 32'hDEAD_BEEF);             // data must come again
      send_word(r_type(FN_ADDU, 14, 0, 15, 0), 32'h8765_4321);
      send_word(r_type(FN_OR, 14, 0, 16, 0), random_load_data());
      send_word(i_type(OP_LW, 0, 0, 16'h0000), random_load_data());
      send_word(32'h0000_0000, random_load_data());
   endtask

   // With the cache isolated, loads and stores issue nothing. A load that
   // was armed before isolation still picks up its data.
   task automatic test_isolated_cache();
      send_word(i_type(OP_LW, 0, 17, 16'h0010), random_load_data());
      set_isolation(1'b1);
      send_word(i_type(OP_LB, 0, 18, 16'h0020), 32'hCAFE_F00D);
      send_word(i_type(OP_SW, 17, 18, 16'h0000), random_load_data());
      send_word(i_type(OP_SH, 17, 18, 16'h0002), random_load_data());
      send_word(i_type(OP_SB, 17, 18, 16'h0003), random_load_data());
      send_word(r_type(FN_ADDU, 17, 0, 19, 0), random_load_data());
      send_word(r_type(FN_OR, 17, 0, 20, 0), random_load_data());
      repeat (150) send_word(random_instr(), random_load_data());
      set_isolation(1'b0);
   endtask

   task automatic test_random_stream(input int unsigned count);
      repeat (count) send_word(random_instr(), random_load_data());
   endtask

   // The receiver holds off while the sender keeps offering, so the block
   // fills and stalls its input; then the sender waits for a full drain.
   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (40) send_word(random_instr(), random_load_data());
      wait_drained();
      repeat (40) send_word(random_instr(), random_load_data());
   endtask

   // A jump through a register to an unaligned address. After its delay
   // slot every word faults and the PC never moves again.
   task automatic test_unaligned_pc();
      send_word(i_type(OP_ADDIU, 0, 21, 16'h0002), random_load_data());
      send_word(r_type(FN_JR, 21, 0, 0, 0), random_load_data());
      send_word(32'h0000_0000, random_load_data());
      repeat (4) send_word(random_instr(), random_load_data());
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      req_valid        = 1'b0;
      req_instr_word   = '0;
      req_load_data    = '0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_request     = 1'b0;
      mismatch_count   = 0;
      words_checked    = 0;
      fault_words      = 0;
      loads_seen       = 0;
      stores_seen      = 0;
      for (int i = 0; i < REG_N; i++)
         rf[i] = '0;
      pc_now       = RESET_PC;
      pc_follow    = RESET_FOLLOW;
      ld_reg       = '0;
      ld_value     = '0;
      ld_wait      = 1'b0;
      ld_byte_flag = 1'b0;
      iso_bit      = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The register is written to its reset value first, then toggled by
      // the isolated-cache test.
      set_isolation(1'b0);

      send_idle_pct = 10;
      recv_idle_pct = 54;
      test_opcodes();
      test_load_slot();
      test_isolated_cache();
      test_random_stream(700);

      send_idle_pct = 54;
      recv_idle_pct = 10;
      test_random_stream(700);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_stream(500);
      test_unaligned_pc();

      // Wait for the last results, then keep watching to catch any
      // word the block should not have produced.
      req_valid = 1'b0;
      while (retire_words_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d result words: %0d faults, %0d loads, %0d stores issued.",
               words_checked, fault_words, loads_seen, stores_seen);
      $display("Covered all opcodes, load slot cases, cache isolation, backpressure, bad PC.");
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
